[src/lse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lse_pkg;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic RK_CHAR     = 1'b0;
   localparam logic RK_LINE_END = 1'b1;

   localparam logic IK_BYTE      = 1'b0;
   localparam logic IK_CHUNK_END = 1'b1;

   typedef enum logic [2:0] {
      PH_TEXT = 3'b001,
      PH_CR   = 3'b010,
      PH_LF   = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      ST_NONE = 2'd0,
      ST_CR   = 2'd1,
      ST_LF   = 2'd2,
      ST_CRLF = 2'd3
   } style_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       final_chunk;
   } item_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] char_out;
      logic       line_empty;
      logic       run_last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

[src/lse_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

module lse_engine
   import lse_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     fire,
   input  wire item_type item,
   output push_type      push
);

   phase_type phase_ff, phase_in;
   style_type style_ff, style_in;
   logic      has_ff, has_in;
   logic      stop_ff, stop_in;
   logic      emit_le, emit_ch;
   result_type le_r, ch_r;

   always_comb begin
      phase_in = phase_ff;
      style_in = style_ff;
      has_in   = has_ff;
      stop_in  = stop_ff;
      emit_le  = 1'b0;
      emit_ch  = 1'b0;
      if (item.kind == IK_CHUNK_END) begin
         if (stop_ff) begin
            stop_in = 1'b0;
         end else if (phase_ff == PH_CR || phase_ff == PH_LF) begin
            phase_in = PH_TEXT;
            emit_le  = 1'b1;
         end else if (item.final_chunk) begin
            emit_le = 1'b1;
         end
      end else if (!stop_ff) begin
         if (item.data_byte == CH_NUL) begin
            stop_in = 1'b1;
         end else if (item.data_byte == CH_CR) begin
            case (style_ff)
               ST_CR:   emit_le = 1'b1;
               ST_LF:   ;
               ST_CRLF: phase_in = PH_CR;
               default: begin
                  unique case (phase_ff)
                     PH_CR: begin
                        style_in = ST_CR;
                        phase_in = PH_TEXT;
                        emit_le  = 1'b1;
                     end
                     PH_LF: begin
                        phase_in = PH_TEXT;
                        emit_le  = 1'b1;
                     end
                     default: phase_in = PH_CR;
                  endcase
               end
            endcase
         end else if (item.data_byte == CH_LF) begin
            case (style_ff)
               ST_CR:   ;
               ST_LF:   emit_le = 1'b1;
               ST_CRLF: begin
                  if (phase_ff == PH_CR) begin
                     phase_in = PH_TEXT;
                     emit_le  = 1'b1;
                  end
               end
               default: begin
                  unique case (phase_ff)
                     PH_CR: begin
                        style_in = ST_CRLF;
                        phase_in = PH_TEXT;
                        emit_le  = 1'b1;
                     end
                     PH_LF: begin
                        style_in = ST_LF;
                        phase_in = PH_TEXT;
                        emit_le  = 1'b1;
                     end
                     default: phase_in = PH_LF;
                  endcase
               end
            endcase
         end else begin
            if (phase_ff == PH_CR) begin
               style_in = ST_CR;
               phase_in = PH_TEXT;
               emit_le  = 1'b1;
            end else if (phase_ff == PH_LF) begin
               style_in = ST_LF;
               phase_in = PH_TEXT;
               emit_le  = 1'b1;
            end
            emit_ch = 1'b1;
         end
      end
      if (emit_le) begin
         has_in = 1'b0;
      end
      if (emit_ch) begin
         has_in = 1'b1;
      end
   end

   always_comb begin
      le_r.result_kind = RK_LINE_END;
      le_r.char_out    = 8'd0;
      le_r.line_empty  = ~has_ff;
      le_r.run_last    = ~emit_ch;
      ch_r.result_kind = RK_CHAR;
      ch_r.char_out    = item.data_byte;
      ch_r.line_empty  = 1'b0;
      ch_r.run_last    = 1'b1;
      push.count  = {1'b0, emit_le} + {1'b0, emit_ch};
      push.first  = emit_le ? le_r : ch_r;
      push.second = ch_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TEXT;
         style_ff <= ST_NONE;
         has_ff   <= 1'b0;
         stop_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         style_ff <= style_in;
         has_ff   <= has_in;
         stop_ff  <= stop_in;
      end
   end

endmodule

`default_nettype wire

[src/lse_outq.sv]
`timescale 1ns / 1ps
`default_nettype none

module lse_outq
   import lse_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_en,
   input  wire push_type push,
   output logic          space,
   output logic          out_valid,
   input  wire logic     out_ready,
   output result_type    out_word
);

   result_type             entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   pop;
   logic [1:0]             push_n;

   assign push_n    = push_en ? push.count : 2'd0;
   assign out_valid = (count_ff != '0);
   assign out_word  = entries_ff[head_ff];
   assign pop       = out_valid && out_ready;
   assign space     = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));

   always_comb begin
      head_in  = head_ff + PTR_W'(pop);
      tail_in  = tail_ff + PTR_W'(push_n);
      count_in = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entries_ff[tail_ff] <= push.first;
      end
      if (push_n == 2'd2) begin
         entries_ff[tail_ff + PTR_W'(1)] <= push.second;
      end
   end

`ifndef SYNTHESIS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("output queue overflow");

   a_push_space: assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0) |-> space)
      else $error("push without room for two words");

   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      (push_n == 2'd2) |-> (!push.first.run_last && push.second.run_last &&
                            push.first.result_kind == RK_LINE_END))
      else $error("bad run_last marking on a result pair");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && push_n == 2'd0) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("count did not drop on pop");
`endif

endmodule

`default_nettype wire

[src/line_splitter_autodetect_eol_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Line splitter with learned line-ending style (CR, LF or CRLF).
// req_ channel: one word per text byte or chunk end. tuser is the kind
// (0 = byte, 1 = chunk end), tdata the byte, tlast marks the final chunk
// on a chunk end.
// rsp_ channel: one word per line character or line end. tuser is the
// result kind (0 = character, 1 = line end), tdata[7:0] the character,
// tdata[8] the empty-line flag, tlast the last word caused by an input.
// A req_ word is held in an input register, decoded against the line
// state, and its zero, one or two results go into a four-word output
// queue. rsp_tvalid rises once they are written into the queue, so each
// result passes the input register and the queue before it can be taken.
// One word per cycle is sustained while the queue has room; decode waits
// while fewer than two queue slots are free.
// A stalled receiver fills the queue, then the input register, then
// req_tready falls. Synchronous reset empties both and returns the state
// to text with the style unknown.
module line_splitter_autodetect_eol_core
   import lse_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic        req_tuser,   // kind
   input  wire logic        req_tlast,   // final_chunk
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // char_out[7:0], line_empty[8], zeros
   output logic             rsp_tuser,   // result_kind
   output logic             rsp_tlast    // run_last
);

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       fire;
   logic       space;
   push_type   push;
   result_type out_word;

   assign fire       = in_valid_ff && space;
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.kind        <= req_tuser;
         in_item_ff.data_byte   <= req_tdata;
         in_item_ff.final_chunk <= req_tlast;
      end
   end

   lse_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_item_ff),
      .push  (push)
   );

   lse_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push_en   (fire),
      .push      (push),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (out_word)
   );

   assign rsp_tdata = {7'd0, out_word.line_empty, out_word.char_out};
   assign rsp_tuser = out_word.result_kind;
   assign rsp_tlast = out_word.run_last;

endmodule

`default_nettype wire
